>>> sv/svf_tpt_pkg.sv
// svf_tpt_pkg: shared constants for the trapezoidal state variable filter.
// Register map, mode codes, reset values and default parameter values.
// No dependencies.
package svf_tpt_pkg;

    // Default parameter values
    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;

    // Field widths fixed by the interface
    localparam int CHAN_BITS = 3;
    localparam int COEF_BITS = 32;
    localparam int H_BITS    = 25;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_G    = 2'd1;
    localparam logic [1:0] REG_R2   = 2'd2;
    localparam logic [1:0] REG_H    = 2'd3;

    // Filter mode codes; anything else selects lowpass
    localparam logic [1:0] MODE_LP = 2'd0;
    localparam logic [1:0] MODE_BP = 2'd1;
    localparam logic [1:0] MODE_HP = 2'd2;

    // Register reset values
    localparam logic [1:0]           MODE_RST = MODE_LP;
    localparam logic [COEF_BITS-1:0] G_RST    = 32'd1197200;
    localparam logic [COEF_BITS-1:0] R2_RST   = 32'd23726566;
    localparam logic [H_BITS-1:0]    H_RST    = 25'd15169125;

endpackage

>>> sv/state_variable_tpt_filter_top.sv
// state_variable_tpt_filter_top: multichannel 2nd-order TPT state variable filter.
// One shared multiplier under a small sequencer; per-channel integrator state store.
// Depends on svf_tpt_pkg.
//
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tdata: sample_in; s_tuser: channel
// m_*       out        m_tvalid/m_tready   m_tdata: sample_out; m_tuser: out_channel
// APB       in/out     psel/penable/pready registers 0..3 at byte addresses 0,4,8,12
//
// Timing: after the input transaction come a state read, the multiplier steps (five
// coefficient products in 16-bit halves) and four summing steps, the first sum sharing
// a cycle with the next product, and then the registered result; one item at a time.
// Out-of-range channels: zero result registered from the skip step, state untouched.
// Reset clears the integrators at once through per-channel valid bits; no clearing pass.
// A result held by a low m_tready stalls the next item at its last step, not its input.
module state_variable_tpt_filter_top
    import svf_tpt_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  logic [CHAN_BITS-1:0]                  s_tuser,   // [2:0] channel
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    output logic [CHAN_BITS-1:0]                  m_tuser,   // [2:0] out_channel
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [CFG_AW-1:0]                     paddr,
    input  logic [CFG_DW-1:0]                     pwdata,
    output logic [CFG_DW-1:0]                     prdata,
    output logic                                  pready
);

    localparam int DW    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SW    = SAMPLE_BITS + 8;          // state width, 8 guard bits
    localparam int PW    = SW + 17;                  // state x 17-bit signed half
    localparam int WW    = SW + 12;                  // headroom for sums
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD,
        S_G_LO, S_G_HI, S_R_LO, S_R_HI, S_V,
        S_H_LO, S_H_HI, S_HP,
        S_HG_LO, S_HG_HI, S_BP,
        S_BG_LO, S_BG_HI, S_LP,
        S_SKIP
    } state_t;

    // saturate a wide intermediate to the state width
    function automatic logic signed [SW-1:0] sat_st(input logic signed [WW-1:0] v);
        logic [WW-SW:0] top;
        top = v[WW-1:SW-1];
        if (top == '0 || top == '1)
            return v[SW-1:0];
        else if (v[WW-1])
            return {1'b1, {(SW-1){1'b0}}};
        else
            return {1'b0, {(SW-1){1'b1}}};
    endfunction

    // saturate a state-width value to the sample width
    function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic signed [SW-1:0] v);
        logic [SW-SAMPLE_BITS:0] top;
        top = v[SW-1:SAMPLE_BITS-1];
        if (top == '0 || top == '1)
            return v[SAMPLE_BITS-1:0];
        else if (v[SW-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    // ---------------------------------------------------------------- registers
    state_t                    state_reg, state_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]             m_tdata_reg, m_tdata_next;
    logic [CHAN_BITS-1:0]      m_tuser_reg, m_tuser_next;
    logic [CHANNELS-1:0]       valid_reg;

    logic [1:0]                mode_reg;
    logic [COEF_BITS-1:0]      g_reg;
    logic [COEF_BITS-1:0]      r2_reg;
    logic [H_BITS-1:0]         h_reg;

    // datapath (no reset)
    logic [CHAN_BITS-1:0]      ch_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SW-1:0]      rd_s1_reg, rd_s2_reg;
    logic                      rd_vld_reg;
    logic signed [SW-1:0]      s1_reg, s2_reg;
    logic signed [WW-1:0]      vpart_reg;
    logic signed [SW-1:0]      v_reg, hp_reg, bp_reg, s1n_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [SW:0]        acc_reg;

    // per-channel integrator store
    logic signed [SW-1:0]      mem_s1 [CHANNELS];
    logic signed [SW-1:0]      mem_s2 [CHANNELS];

    // ---------------------------------------------------------------- comb
    logic                      s_accept;
    logic                      chan_ok;
    logic                      out_free;
    logic                      wr_en;
    logic [CH_AW-1:0]          rd_addr, wr_addr;
    logic signed [SW-1:0]      mul_a;
    logic [15:0]               mul_b;
    logic signed [PW-1:0]      mul_p;
    logic signed [PW-1:0]      mq_sum;
    logic signed [WW-1:0]      mq;
    logic signed [SW-1:0]      bp_w, s1n_w, lp_w, s2n_w, sel_w;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign chan_ok  = (7'(s_tuser) < 7'(CHANNELS));
    assign out_free = !m_tvalid_reg || m_tready;
    assign wr_en    = (state_reg == S_LP) && out_free;
    assign rd_addr  = CH_AW'(s_tuser);
    assign wr_addr  = CH_AW'(ch_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;

    // shared multiplier operand selection: state x one 16-bit coefficient half
    always_comb begin
        case (state_reg)
            S_H_LO, S_H_HI:   mul_a = v_reg;
            S_HG_LO, S_HG_HI: mul_a = hp_reg;
            S_BG_LO, S_BG_HI: mul_a = bp_reg;
            default:          mul_a = s1_reg;
        endcase
        case (state_reg)
            S_G_HI, S_HG_HI, S_BG_HI: mul_b = g_reg[31:16];
            S_R_LO:                   mul_b = r2_reg[15:0];
            S_R_HI:                   mul_b = r2_reg[31:16];
            S_H_LO:                   mul_b = h_reg[15:0];
            S_H_HI:                   mul_b = {7'd0, h_reg[24:16]};
            default:                  mul_b = g_reg[15:0];
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'($signed({1'b0, mul_b}));

    // floor(a*c / 2^24) = (hi + floor(lo / 2^16)) >>> 8
    assign mq_sum = PW'(acc_reg) + prod_reg;
    assign mq     = WW'($signed(mq_sum[PW-1:8]));

    assign bp_w  = sat_st(mq + WW'(s1_reg));
    assign s1n_w = sat_st(mq + WW'(bp_w));
    assign lp_w  = sat_st(mq + WW'(s2_reg));
    assign s2n_w = sat_st(mq + WW'(lp_w));

    always_comb begin
        case (mode_reg)
            MODE_BP: sel_w = bp_reg;
            MODE_HP: sel_w = hp_reg;
            default: sel_w = lp_w;
        endcase
    end

    // sequencer next state and output register
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept)
                    state_next = chan_ok ? S_LOAD : S_SKIP;
            end
            S_LOAD:  state_next = S_G_LO;
            S_G_LO:  state_next = S_G_HI;
            S_G_HI:  state_next = S_R_LO;
            S_R_LO:  state_next = S_R_HI;
            S_R_HI:  state_next = S_V;
            S_V:     state_next = S_H_LO;
            S_H_LO:  state_next = S_H_HI;
            S_H_HI:  state_next = S_HP;
            S_HP:    state_next = S_HG_LO;
            S_HG_LO: state_next = S_HG_HI;
            S_HG_HI: state_next = S_BP;
            S_BP:    state_next = S_BG_LO;
            S_BG_LO: state_next = S_BG_HI;
            S_BG_HI: state_next = S_LP;
            S_LP: begin
                // products stay put while the previous result is still held
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = DW'(sat_out(sel_w));
                    m_tuser_next  = ch_reg;
                    state_next    = S_IDLE;
                end
            end
            S_SKIP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = ch_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state, result register, valid bits and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            valid_reg    <= '0;
            mode_reg     <= MODE_RST;
            g_reg        <= G_RST;
            r2_reg       <= R2_RST;
            h_reg        <= H_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_MODE: mode_reg <= pwdata[1:0];
                    REG_G:    g_reg    <= pwdata;
                    REG_R2:   r2_reg   <= pwdata;
                    REG_H:    h_reg    <= pwdata[H_BITS-1:0];
                    default:  ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE: prdata = CFG_DW'(mode_reg);
            REG_G:    prdata = g_reg;
            REG_R2:   prdata = r2_reg;
            REG_H:    prdata = CFG_DW'(h_reg);
            default:  prdata = '0;
        endcase
    end

    // integrator store: one read port at acceptance, one write port at the end
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_s1_reg  <= mem_s1[rd_addr];
            rd_s2_reg  <= mem_s2[rd_addr];
            rd_vld_reg <= valid_reg[rd_addr];
        end
        if (wr_en) begin
            mem_s1[wr_addr] <= s1n_reg;
            mem_s2[wr_addr] <= s2n_w;
        end
    end

    // arithmetic datapath
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_reg <= s_tuser;
            x_reg  <= $signed(s_tdata[SAMPLE_BITS-1:0]);
        end
        case (state_reg)
            S_LOAD: begin
                s1_reg <= rd_vld_reg ? rd_s1_reg : '0;
                s2_reg <= rd_vld_reg ? rd_s2_reg : '0;
            end
            S_G_LO, S_H_LO, S_HG_LO, S_BG_LO: begin
                prod_reg <= mul_p;
            end
            S_G_HI, S_R_HI, S_H_HI, S_HG_HI, S_BG_HI: begin
                acc_reg  <= $signed(prod_reg[PW-1:16]);
                prod_reg <= mul_p;
            end
            S_R_LO: begin
                // x - s1*g - s2; s1*R2 follows
                vpart_reg <= WW'(x_reg) - mq - WW'(s2_reg);
                prod_reg  <= mul_p;
            end
            S_V: begin
                v_reg <= sat_st(vpart_reg - mq);
            end
            S_HP: begin
                hp_reg <= sat_st(mq);
            end
            S_BP: begin
                bp_reg  <= bp_w;
                s1n_reg <= s1n_w;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // a result appears only from the final step or the out-of-range path
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == S_LP || $past(state_reg) == S_SKIP))
        else $error("result raised outside final step");

    // one item at a time: busy straight after a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // out-of-range channel bypasses the arithmetic and the store
    a_bad_chan_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !chan_ok) |=> (state_reg == S_SKIP))
        else $error("out-of-range channel entered the datapath");
`endif

endmodule
